// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types and helpers for the curve similarity test
// Sample and threshold widths, the result record handed from the
// accumulator to the threshold check, and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Sample width of both curves, two's complement
  localparam int SAMPLE_BITS = 16;
  // Fraction bits of the Q format threshold
  localparam int THR_FRAC_BITS = 8;
  // Threshold register width
  localparam int THR_W = 16;
  // Accumulator width
  localparam int ACC_W = 64;
  // Reset value of the threshold register
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(26);

  // Square widths: sample magnitude squared, difference magnitude squared
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SQD_W = 2 * (SAMPLE_BITS + 1);

  // Queue between accumulator and threshold check
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Threshold product width and compare width
  localparam int HALF_W = ACC_W / 2;
  localparam int PP_W   = THR_W + HALF_W;
  localparam int CMP_W  = ACC_W + THR_W;

  // Finished sums of one comparison
  typedef struct packed {
    logic [ACC_W-1:0] diff_sum;
    logic [ACC_W-1:0] area_first;
    logic [ACC_W-1:0] area_second;
    logic [THR_W-1:0] threshold;
  } cst_sums_t;

  // Clamp a wide square to the accumulator width
  function automatic logic [ACC_W-1:0] sat_sq(input logic [2*ACC_W-1:0] sq);
    logic [ACC_W-1:0] res;
    res = (|sq[2*ACC_W-1:ACC_W]) ? {ACC_W{1'b1}} : sq[ACC_W-1:0];
    return res;
  endfunction

  // Saturating add at the accumulator width
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/curve_similarity_test.sv =====
// ----------------------------------------------------------------------------
// curve_similarity_test: sum of squared differences between two curves
// Streams pairs of samples, keeps saturating sums of squares of each curve
// and of their difference, and judges a match on the last pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per pair of samples. A
//   sample whose has flag is low counts as zero. in_last_pair closes the
//   comparison; only that beat produces a result.
//   Output channel (out_valid/out_ready): one beat per comparison with the
//   match flag, the difference sum and the larger area. A match means the
//   larger area is nonzero and diff * 2^8 < threshold * larger_area.
//   Config: cfg_wr_en writes cfg_wr_data into the Q8.8 threshold; write it
//   only while no comparison is in flight.
//   Throughput: one pair per cycle, including back-to-back last pairs, except
//   while a last pair waits on a full queue. After the last pair is accepted,
//   its result passes accumulate and queue write, max select, threshold
//   multiply, and compare and result register before the beat is valid.
//   Reset clears the sums, the queue and the pipeline and sets the
//   threshold to 26. When the receiver stalls, the result beat holds, the
//   check pipe stops with up to three comparisons in it, four more finished
//   comparisons queue up, and in_ready then drops while the next last pair
//   waits in the square stage.
// ----------------------------------------------------------------------------
module curve_similarity_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cst_pkg::SAMPLE_BITS-1:0] in_sample_a,
  input  logic signed [cst_pkg::SAMPLE_BITS-1:0] in_sample_b,
  input  logic                                   in_has_a,
  input  logic                                   in_has_b,
  input  logic                                   in_last_pair,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_is_match,
  output logic [cst_pkg::ACC_W-1:0]              out_diff_energy,
  output logic [cst_pkg::ACC_W-1:0]              out_larger_area,
  input  logic                                   cfg_wr_en,
  input  logic [cst_pkg::THR_W-1:0]              cfg_wr_data
);
  import cst_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             q_full, q_empty, q_push, q_pop;
  cst_sums_t        q_push_data, q_pop_data;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Accumulator
  cst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .in_has_a    (in_has_a),
    .in_has_b    (in_has_b),
    .in_last_pair(in_last_pair),
    .threshold   (thr_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Queue of finished sums
  cst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  // Threshold check and result
  cst_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_pop_data     (q_pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_match   (out_is_match),
    .out_diff_energy(out_diff_energy),
    .out_larger_area(out_larger_area)
  );

endmodule

// ===== rtl/cst_front.sv =====
// ----------------------------------------------------------------------------
// cst_front: sample squaring and saturating accumulation
// Squares each accepted pair, adds the squares into the three running sums
// and pushes the finished sums to the queue on the last pair.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cst_pkg::SAMPLE_BITS-1:0] in_sample_a,
  input  logic signed [cst_pkg::SAMPLE_BITS-1:0] in_sample_b,
  input  logic                                  in_has_a,
  input  logic                                  in_has_b,
  input  logic                                  in_last_pair,
  input  logic [cst_pkg::THR_W-1:0]             threshold,
  input  logic                                  q_full,
  output logic                                  q_push,
  output cst_pkg::cst_sums_t                    q_push_data
);
  import cst_pkg::*;

  logic signed [SAMPLE_BITS-1:0] a_val, b_val;
  logic signed [SAMPLE_BITS:0]   d_val;
  logic [SAMPLE_BITS-1:0]        mag_a, mag_b;
  logic [SAMPLE_BITS:0]          mag_d;

  logic              s1_v_r, s1_last_r;
  logic [SQ_W-1:0]   sq_a_r, sq_b_r;
  logic [SQD_W-1:0]  sq_d_r;
  logic              s1_go, in_acc;

  logic [ACC_W-1:0]  area_a_r, area_b_r, diff_r;
  logic [ACC_W-1:0]  area_a_nxt, area_b_nxt, diff_nxt;

  // Zero absent samples, form difference and magnitudes
  always_comb begin
    a_val = in_has_a ? in_sample_a : '0;
    b_val = in_has_b ? in_sample_b : '0;
    d_val = (SAMPLE_BITS+1)'(a_val) - (SAMPLE_BITS+1)'(b_val);
    mag_a = a_val[SAMPLE_BITS-1] ? SAMPLE_BITS'(-a_val) : SAMPLE_BITS'(a_val);
    mag_b = b_val[SAMPLE_BITS-1] ? SAMPLE_BITS'(-b_val) : SAMPLE_BITS'(b_val);
    mag_d = d_val[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_val) : (SAMPLE_BITS+1)'(d_val);
  end

  // Hold the square stage only when a last pair meets a full queue
  assign s1_go    = !(s1_v_r && s1_last_r && q_full);
  assign in_ready = s1_go;
  assign in_acc   = in_valid && in_ready;

  // Square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_a_r    <= SQ_W'(mag_a) * SQ_W'(mag_a);
      sq_b_r    <= SQ_W'(mag_b) * SQ_W'(mag_b);
      sq_d_r    <= SQD_W'(mag_d) * SQD_W'(mag_d);
      s1_last_r <= in_last_pair;
    end
  end

  // Accumulate squares with saturation
  always_comb begin
    area_a_nxt = sat_add(area_a_r, sat_sq((2*ACC_W)'(sq_a_r)));
    area_b_nxt = sat_add(area_b_r, sat_sq((2*ACC_W)'(sq_b_r)));
    diff_nxt   = sat_add(diff_r, sat_sq((2*ACC_W)'(sq_d_r)));
  end

  assign q_push = s1_v_r && s1_last_r && !q_full;

  always_comb begin
    q_push_data.diff_sum    = diff_nxt;
    q_push_data.area_first  = area_a_nxt;
    q_push_data.area_second = area_b_nxt;
    q_push_data.threshold   = threshold;
  end

  // Advance sums; clear them once the last pair is pushed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_a_r <= '0;
      area_b_r <= '0;
      diff_r   <= '0;
    end else if (s1_v_r && s1_go) begin
      if (s1_last_r) begin
        area_a_r <= '0;
        area_b_r <= '0;
        diff_r   <= '0;
      end else begin
        area_a_r <= area_a_nxt;
        area_b_r <= area_b_nxt;
        diff_r   <= diff_nxt;
      end
    end
  end

endmodule

// ===== rtl/cst_queue.sv =====
// ----------------------------------------------------------------------------
// cst_queue: short queue of finished sums
// Decouples the accumulator from the threshold check so either side can
// stall without holding up the other until the queue fills.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cst_pkg::cst_sums_t push_data,
  output logic               full,
  input  logic               pop,
  output cst_pkg::cst_sums_t pop_data,
  output logic               empty
);
  import cst_pkg::*;

  cst_sums_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r;

  assign full     = (count_r == Q_CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cst_back.sv =====
// ----------------------------------------------------------------------------
// cst_back: threshold check and result register
// Picks the larger area, multiplies it by the threshold in two halves and
// compares against the scaled difference, then holds the result beat.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  cst_pkg::cst_sums_t         q_pop_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_match,
  output logic [cst_pkg::ACC_W-1:0]  out_diff_energy,
  output logic [cst_pkg::ACC_W-1:0]  out_larger_area
);
  import cst_pkg::*;

  logic              adv;
  logic              b1_v_r, b2_v_r, out_v_r;
  logic [ACC_W-1:0]  b1_diff_r, b1_larger_r, b2_diff_r, b2_larger_r;
  logic [THR_W-1:0]  b1_thr_r;
  logic [PP_W-1:0]   b2_plo_r, b2_phi_r;
  logic [ACC_W-1:0]  larger;
  logic [CMP_W-1:0]  lhs, rhs;
  logic              match;

  // Whole pipe moves when the result register is free
  assign adv   = !out_v_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= !q_empty;
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r;
    end
  end

  // Select the larger area
  assign larger = (q_pop_data.area_first > q_pop_data.area_second) ?
                  q_pop_data.area_first : q_pop_data.area_second;

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_diff_r   <= q_pop_data.diff_sum;
      b1_larger_r <= larger;
      b1_thr_r    <= q_pop_data.threshold;
    end
  end

  // Partial products of threshold times larger area
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_diff_r   <= b1_diff_r;
      b2_larger_r <= b1_larger_r;
      b2_plo_r    <= PP_W'(b1_thr_r) * PP_W'(b1_larger_r[HALF_W-1:0]);
      b2_phi_r    <= PP_W'(b1_thr_r) * PP_W'(b1_larger_r[ACC_W-1:HALF_W]);
    end
  end

  // Combine halves and compare against the scaled difference
  always_comb begin
    rhs   = CMP_W'(b2_plo_r) + (CMP_W'(b2_phi_r) << HALF_W);
    lhs   = CMP_W'(b2_diff_r) << THR_FRAC_BITS;
    match = (b2_larger_r != '0) && (lhs < rhs);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_is_match    <= match;
      out_diff_energy <= b2_diff_r;
      out_larger_area <= b2_larger_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== test/curve_similarity_test_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// curve_similarity_test_tb: self-checking bench for the curve similarity test
// Streams pairs of samples through the input channel and folds each beat into
// running sums of squares kept by the bench. On every last pair it predicts
// the difference sum, the larger area and the match flag. Each result beat
// is checked against the oldest prediction. The run covers directed corner
// curves, threshold edges and three idle/stall mixes of random curves.
// ----------------------------------------------------------------------------
module curve_similarity_test_tb;

  localparam int SB          = cst_pkg::SAMPLE_BITS;
  localparam int ACC         = cst_pkg::ACC_W;
  localparam int TW          = cst_pkg::THR_W;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CHUNK_PAIRS = 137;

  // One beat of the input channel
  typedef struct {
    logic signed [SB-1:0] sample_a;
    logic signed [SB-1:0] sample_b;
    logic                 has_a;
    logic                 has_b;
    logic                 last_pair;
  } pair_t;

  // One predicted result beat
  typedef struct {
    logic           is_match;
    logic [ACC-1:0] diff_energy;
    logic [ACC-1:0] larger_area;
  } verdict_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SB-1:0] in_sample_a = '0;
  logic signed [SB-1:0] in_sample_b = '0;
  logic                 in_has_a = 1'b0;
  logic                 in_has_b = 1'b0;
  logic                 in_last_pair = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_is_match;
  logic [ACC-1:0]       out_diff_energy;
  logic [ACC-1:0]       out_larger_area;
  logic                 cfg_wr_en = 1'b0;
  logic [TW-1:0]        cfg_wr_data = '0;

  // Bench copy of the block state
  logic [ACC-1:0] sum_sq_first;
  logic [ACC-1:0] sum_sq_second;
  logic [ACC-1:0] sum_sq_diff;
  logic [TW-1:0]  threshold_q8;

  pair_t    pair_q[$];
  verdict_t verdict_q[$];
  pair_t    next_pair;

  logic in_beat_taken = 1'b0;
  int   send_gap_pct = 29;
  int   recv_stall_pct = 57;
  int   pairs_queued = 0;
  int   pairs_taken = 0;
  int   results_checked = 0;
  int   matches_seen = 0;
  int   thr_writes = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  curve_similarity_test DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_a     (in_sample_a),
    .in_sample_b     (in_sample_b),
    .in_has_a        (in_has_a),
    .in_has_b        (in_has_b),
    .in_last_pair    (in_last_pair),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_match    (out_is_match),
    .out_diff_energy (out_diff_energy),
    .out_larger_area (out_larger_area),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [ACC-1:0] magnitude(input longint x);
    return (x < 0) ? ACC'(-x) : ACC'(x);
  endfunction

  // Square a magnitude, clamp at all ones
  function automatic logic [ACC-1:0] square_clamped(input logic [ACC-1:0] m);
    return (m > 64'hFFFF_FFFF) ? {ACC{1'b1}} : m * m;
  endfunction

  function automatic logic [ACC-1:0] add_clamped(input logic [ACC-1:0] a,
                                                 input logic [ACC-1:0] b);
    logic [ACC:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC] ? {ACC{1'b1}} : s[ACC-1:0];
  endfunction

  // Fold one accepted beat into the sums; on a last pair predict the result
  task automatic fold_pair(input logic signed [SB-1:0] sa, input logic signed [SB-1:0] sb,
                           input logic ha, input logic hb, input logic last);
    longint         va;
    longint         vb;
    logic [ACC-1:0] larger;
    logic [127:0]   lhs;
    logic [127:0]   rhs;
    verdict_t       v;
    va = ha ? longint'(sa) : 64'sd0;
    vb = hb ? longint'(sb) : 64'sd0;
    sum_sq_first  = add_clamped(sum_sq_first, square_clamped(magnitude(va)));
    sum_sq_second = add_clamped(sum_sq_second, square_clamped(magnitude(vb)));
    sum_sq_diff   = add_clamped(sum_sq_diff, square_clamped(magnitude(va - vb)));
    if (last) begin
      larger = (sum_sq_first > sum_sq_second) ? sum_sq_first : sum_sq_second;
      lhs = {64'd0, sum_sq_diff} << cst_pkg::THR_FRAC_BITS;
      rhs = {112'd0, threshold_q8} * {64'd0, larger};
      v.is_match    = (larger != '0) && (lhs < rhs);
      v.diff_energy = sum_sq_diff;
      v.larger_area = larger;
      verdict_q.push_back(v);
      sum_sq_first  = '0;
      sum_sq_second = '0;
      sum_sq_diff   = '0;
    end
  endtask

  // Track config and input beats, check result beats
  always @(posedge clk) begin
    in_beat_taken <= in_valid && in_ready;
    if (!rst_n) begin
      sum_sq_first  = '0;
      sum_sq_second = '0;
      sum_sq_diff   = '0;
      threshold_q8  = cst_pkg::THR_RESET;
    end else begin
      if (cfg_wr_en) begin
        threshold_q8 = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        pairs_taken++;
        fold_pair(in_sample_a, in_sample_b, in_has_a, in_has_b, in_last_pair);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (verdict_q.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected: match %0b diff %0d area %0d",
                   $time, out_is_match, out_diff_energy, out_larger_area);
        end else begin
          verdict_t v;
          v = verdict_q.pop_front();
          if (v.is_match) matches_seen++;
          if (out_is_match !== v.is_match) begin
            error_count++;
            $display("%0t: is_match expected %0b actual %0b", $time, v.is_match, out_is_match);
          end
          if (out_diff_energy !== v.diff_energy) begin
            error_count++;
            $display("%0t: diff_energy expected %0d actual %0d",
                     $time, v.diff_energy, out_diff_energy);
          end
          if (out_larger_area !== v.larger_area) begin
            error_count++;
            $display("%0t: larger_area expected %0d actual %0d",
                     $time, v.larger_area, out_larger_area);
          end
        end
      end
    end
  end

  // Drive input beats from the pending queue, stall the result side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (pair_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_pair = pair_q.pop_front();
        in_valid     <= 1'b1;
        in_sample_a  <= next_pair.sample_a;
        in_sample_b  <= next_pair.sample_b;
        in_has_a     <= next_pair.has_a;
        in_has_b     <= next_pair.has_b;
        in_last_pair <= next_pair.last_pair;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_pair(input int sa, input int sb, input logic ha, input logic hb,
                           input logic last);
    pair_t p;
    p.sample_a  = SB'(sa);
    p.sample_b  = SB'(sb);
    p.has_a     = ha;
    p.has_b     = hb;
    p.last_pair = last;
    pair_q.push_back(p);
    pairs_queued++;
  endtask

  // Hold off the sender until every beat is in and every result is out
  task automatic settle(input int tail);
    while (pairs_taken != pairs_queued || verdict_q.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [TW-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    thr_writes++;
  endtask

  function automatic int clamp_sample(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Queue one comparison of the given length and flavor
  task automatic queue_curve(input int len, input int flavor);
    int amp;
    int noise;
    int cut;
    int sa;
    int sb;
    logic ha;
    logic hb;
    logic pad_b;
    amp   = $urandom_range(32767, 1);
    noise = $urandom_range(amp / 4);
    cut   = $urandom_range(len - 1);
    pad_b = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      sa = int'($urandom_range(65535)) - 32768;
      sb = int'($urandom_range(65535)) - 32768;
      ha = 1'b1;
      hb = 1'b1;
      case (flavor)
        0: begin
          // similar curves: b tracks a with a little noise
          sa = int'($urandom_range(2 * amp)) - amp;
          sb = clamp_sample(sa + int'($urandom_range(2 * noise)) - noise);
        end
        1: ;
        2: begin
          // one curve shorter than the other, absent samples keep their value bits
          sa = int'($urandom_range(2 * amp)) - amp;
          sb = clamp_sample(sa + int'($urandom_range(2 * noise)) - noise);
          if (i >= cut) begin
            if (pad_b) hb = 1'b0;
            else ha = 1'b0;
          end
        end
        3: begin
          ha = 1'($urandom_range(1));
          hb = 1'($urandom_range(1));
        end
        4: begin
          sa = pick_extreme();
          sb = pick_extreme();
        end
        default: begin
          ha = ($urandom_range(3) == 0);
          hb = ($urandom_range(3) == 0);
          if (ha) sa = 0;
        end
      endcase
      push_pair(sa, sb, ha, hb, i == len - 1);
    end
  endtask

  initial begin
    int chunk_end;
    int len;
    int flavor;
    logic [TW-1:0] thr;

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed curves at the reset threshold
    push_pair(5, -7, 1'b0, 1'b0, 1'b1);            // both curves empty
    push_pair(-32768, 32767, 1'b1, 1'b1, 1'b1);    // widest difference
    push_pair(32767, -32768, 1'b1, 1'b1, 1'b1);
    push_pair(1234, 1234, 1'b1, 1'b1, 1'b1);       // identical curves
    push_pair(-32768, 9, 1'b0, 1'b1, 1'b1);        // absent sample with bits set
    push_pair(0, 0, 1'b1, 1'b1, 1'b1);             // present but zero area
    push_pair(100, 98, 1'b1, 1'b1, 1'b0);          // second curve padded at the end
    push_pair(200, 205, 1'b1, 1'b1, 1'b0);
    push_pair(-300, -290, 1'b1, 1'b1, 1'b0);
    push_pair(50, -1, 1'b1, 1'b0, 1'b0);
    push_pair(60, -1, 1'b1, 1'b0, 1'b1);
    push_pair(-1, 32767, 1'b1, 1'b0, 1'b0);        // first curve only
    push_pair(-1, -32768, 1'b1, 1'b0, 1'b1);
    push_pair(0, 0, 1'b0, 1'b1, 1'b0);             // second curve only
    push_pair(-5, 7, 1'b0, 1'b1, 1'b1);
    settle(TAIL_CYCLES);

    // Threshold of one: equal difference and area sits on the edge
    write_threshold(16'd256);
    push_pair(0, 300, 1'b1, 1'b1, 1'b1);
    push_pair(1, 300, 1'b1, 1'b1, 1'b1);
    settle(TAIL_CYCLES);

    // Zero threshold never matches
    write_threshold(16'd0);
    push_pair(777, 777, 1'b1, 1'b1, 1'b1);
    push_pair(-32768, -32768, 1'b1, 1'b1, 1'b1);
    settle(TAIL_CYCLES);

    // Largest threshold
    write_threshold(16'hFFFF);
    push_pair(32767, -32768, 1'b1, 1'b1, 1'b1);
    push_pair(0, 0, 1'b0, 1'b0, 1'b1);
    settle(TAIL_CYCLES);

    // Random curves: three idle mixes, four threshold settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct   = 29;
          recv_stall_pct = 57;
        end
        1: begin
          send_gap_pct   = 57;
          recv_stall_pct = 29;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int st = 0; st < 4; st++) begin
        case (ph * 4 + st)
          0, 9:    thr = cst_pkg::THR_RESET;
          1, 7:    thr = 16'hFFFF;
          2, 11:   thr = 16'd0;
          4:       thr = 16'd1;
          5:       thr = TW'($urandom_range(1023));
          6:       thr = 16'd256;
          default: thr = TW'($urandom_range(65535));
        endcase
        write_threshold(thr);
        chunk_end = pairs_queued + CHUNK_PAIRS;
        while (pairs_queued < chunk_end) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
          flavor = ($urandom_range(9) < 6) ? $urandom_range(2) : $urandom_range(5, 3);
          queue_curve(len, flavor);
          // now and then let the results drain mid-stream
          if ($urandom_range(15) == 0) settle(0);
        end
        settle(TAIL_CYCLES);
      end
    end

    $display("covered %0d sample pairs in %0d comparisons (%0d matches), %0d threshold writes",
             pairs_taken, results_checked, matches_seen, thr_writes);
    $display("three sender/receiver idle mixes, %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
